// ===== rtl/mfle_pkg.sv =====
// shared constants, opcodes, link byte codes and controller/datapath bundles
// for the monochrome frame buffer line engine; no dependencies
`default_nettype none

package mfle_pkg;

  localparam int BANKS_DEF = 16;
  localparam int ROWS_DEF  = 32;

  // opcodes
  localparam logic [2:0] OP_SET     = 3'd0;
  localparam logic [2:0] OP_CLR     = 3'd1;
  localparam logic [2:0] OP_DRAW    = 3'd2;
  localparam logic [2:0] OP_ERASE   = 3'd3;
  localparam logic [2:0] OP_FILL    = 3'd4;
  localparam logic [2:0] OP_CLEAR   = 3'd5;
  localparam logic [2:0] OP_REFRESH = 3'd6;

  // display link framing
  localparam logic [7:0] SYNC_CMD    = 8'hF8;
  localparam logic [7:0] SYNC_DATA   = 8'hFA;
  localparam logic [7:0] CMD_MARK    = 8'h80;
  localparam logic [7:0] NIBBLE_MASK = 8'hF0;

  localparam int          REF_BYTES = 12;
  localparam logic [3:0]  LAST_BYTE = 4'(REF_BYTES - 1);

  typedef struct packed {
    logic       load;
    logic       load_sorted;
    logic       pix_rd;
    logic       pix_wr;
    logic       pix_on;
    logic       step;
    logic       mark_skip;
    logic       sweep_wr;
    logic       fill_ones;
    logic       ref_rd;
    logic       emit;
    logic       emit_ref;
    logic       last;
    logic [3:0] byte_sel;
  } mfle_cmd_t;

  typedef struct packed {
    logic diag;
    logic at_end;
    logic on_screen;
    logic sweep_last;
  } mfle_status_t;

  // one byte of the twelve byte refresh sequence: row cmd, bank cmd, high, low
  function automatic logic [7:0] frame_byte(input logic [3:0]  sel,
                                            input logic [4:0]  row,
                                            input logic [3:0]  bank,
                                            input logic [15:0] word);
    logic [7:0] row_cmd;
    logic [7:0] bank_cmd;
    logic [7:0] b;
    row_cmd  = CMD_MARK | {3'b000, row};
    bank_cmd = CMD_MARK | {4'b0000, bank};
    case (sel)
      4'd0:    b = SYNC_CMD;
      4'd1:    b = row_cmd & NIBBLE_MASK;
      4'd2:    b = {row_cmd[3:0], 4'b0000};
      4'd3:    b = SYNC_CMD;
      4'd4:    b = bank_cmd & NIBBLE_MASK;
      4'd5:    b = {bank_cmd[3:0], 4'b0000};
      4'd6:    b = SYNC_DATA;
      4'd7:    b = word[15:8] & NIBBLE_MASK;
      4'd8:    b = {word[11:8], 4'b0000};
      4'd9:    b = SYNC_DATA;
      4'd10:   b = word[7:0] & NIBBLE_MASK;
      4'd11:   b = {word[3:0], 4'b0000};
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mfle_ctrl.sv =====
// controller state machine: sequences pixel read-modify-write, line walk,
// store sweeps and refresh byte output; uses mfle_pkg
`default_nettype none

module mfle_ctrl import mfle_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [2:0]   opcode,
  input  wire mfle_status_t st,
  output logic              busy,
  output mfle_cmd_t         cmd
);

  localparam logic [2:0] ST_INIT    = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_PIX     = 3'd2;
  localparam logic [2:0] ST_PIX_WR  = 3'd3;
  localparam logic [2:0] ST_SWEEP   = 3'd4;
  localparam logic [2:0] ST_REF_RD  = 3'd5;
  localparam logic [2:0] ST_REF_OUT = 3'd6;
  localparam logic [2:0] ST_DONE    = 3'd7;

  logic [2:0] state, state_next;
  logic [3:0] cnt, cnt_next;
  logic       op_line, op_on, op_fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_line <= (opcode == OP_DRAW) || (opcode == OP_ERASE);
      op_on   <= ~opcode[0];
      op_fill <= (opcode == OP_FILL);
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_INIT: begin
        // clearing pass after reset
        cmd.sweep_wr = 1'b1;
        if (st.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load        = 1'b1;
          cmd.load_sorted = (opcode == OP_DRAW) || (opcode == OP_ERASE);
          unique case (opcode) inside
            OP_SET, OP_CLR, OP_DRAW, OP_ERASE: state_next = ST_PIX;
            OP_FILL, OP_CLEAR:                 state_next = ST_SWEEP;
            OP_REFRESH:                        state_next = ST_REF_RD;
            default:                           state_next = ST_DONE;
          endcase
        end
      end
      ST_PIX: begin
        if (op_line && st.diag && st.at_end) begin
          // diagonal walk stops short of its end point
          state_next = ST_DONE;
        end else if (!st.on_screen) begin
          cmd.mark_skip = 1'b1;
          if (!op_line || st.at_end) begin
            state_next = ST_DONE;
          end else begin
            cmd.step = 1'b1;
          end
        end else begin
          cmd.pix_rd = 1'b1;
          state_next = ST_PIX_WR;
        end
      end
      ST_PIX_WR: begin
        cmd.pix_wr = 1'b1;
        cmd.pix_on = op_on;
        if (!op_line || st.at_end) begin
          state_next = ST_DONE;
        end else begin
          cmd.step   = 1'b1;
          state_next = ST_PIX;
        end
      end
      ST_SWEEP: begin
        cmd.sweep_wr  = 1'b1;
        cmd.fill_ones = op_fill;
        if (st.sweep_last) state_next = ST_DONE;
      end
      ST_REF_RD: begin
        cmd.ref_rd = 1'b1;
        cnt_next   = '0;
        state_next = ST_REF_OUT;
      end
      ST_REF_OUT: begin
        cmd.emit     = 1'b1;
        cmd.emit_ref = 1'b1;
        cmd.byte_sel = cnt;
        cmd.last     = (cnt == LAST_BYTE);
        if (cnt == LAST_BYTE) begin
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      ST_DONE: begin
        cmd.emit   = 1'b1;
        cmd.last   = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/mfle_datapath.sv =====
// datapath: item registers, line walk coordinates, frame store memory,
// sweep counter and result registers; uses mfle_pkg
`default_nettype none

module mfle_datapath import mfle_pkg::*; #(
  parameter int BANKS = BANKS_DEF,
  parameter int ROWS  = ROWS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire mfle_cmd_t  cmd,
  input  wire logic [7:0] start_x,
  input  wire logic [7:0] start_y,
  input  wire logic [7:0] end_x,
  input  wire logic [7:0] end_y,
  input  wire logic [3:0] word_bank,
  input  wire logic [4:0] word_row,
  output mfle_status_t    st,
  output logic            strobe,
  output logic [7:0]      serial_byte,
  output logic            byte_valid,
  output logic            out_of_range,
  output logic            last
);

  localparam int DEPTH      = BANKS * ROWS;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int HALF_BANKS = BANKS / 2;
  localparam int SCREEN_W   = HALF_BANKS * 16;
  localparam int SCREEN_H   = 2 * ROWS;

  logic [15:0]       mem [DEPTH];
  logic [15:0]       rd_data;
  logic [7:0]        cx, cy, ex, ey;
  logic              diag;
  logic              skip;
  logic [3:0]        wb;
  logic [4:0]        wr;
  logic [ADDR_W-1:0] sweep_idx;

  logic [4:0]        pix_bank;
  logic [7:0]        pix_row;
  logic [ADDR_W-1:0] pix_addr;
  logic [ADDR_W-1:0] ref_addr;
  logic              ref_ok;
  logic [15:0]       mask;
  logic [15:0]       pix_word;
  logic [15:0]       ref_word;
  logic [7:0]        lo_x, hi_x, lo_y, hi_y;

  // sorted ends for lines
  assign lo_x = (start_x > end_x) ? end_x : start_x;
  assign hi_x = (start_x > end_x) ? start_x : end_x;
  assign lo_y = (start_y > end_y) ? end_y : start_y;
  assign hi_y = (start_y > end_y) ? start_y : end_y;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wb <= word_bank;
      wr <= word_row;
      if (cmd.load_sorted) begin
        cx   <= lo_x;
        cy   <= lo_y;
        ex   <= hi_x;
        ey   <= hi_y;
        diag <= (lo_x != hi_x) && (lo_y != hi_y);
      end else begin
        cx   <= start_x;
        cy   <= start_y;
        ex   <= start_x;
        ey   <= start_y;
        diag <= 1'b0;
      end
    end else if (cmd.step) begin
      if (cx < ex) cx <= cx + 8'd1;
      if (cy < ey) cy <= cy + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      skip <= 1'b0;
    end else if (cmd.mark_skip) begin
      skip <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      sweep_idx <= '0;
    end else if (cmd.sweep_wr) begin
      sweep_idx <= sweep_idx + ADDR_W'(1);
    end
  end

  // pixel address: lower half of the screen lives in the upper banks
  always_comb begin
    if ({1'b0, cy} >= 9'(ROWS)) begin
      pix_bank = {1'b0, cx[7:4]} + 5'(HALF_BANKS);
      pix_row  = cy - 8'(ROWS);
    end else begin
      pix_bank = {1'b0, cx[7:4]};
      pix_row  = cy;
    end
    pix_addr = ADDR_W'(32'(pix_bank) * ROWS + 32'(pix_row));
  end

  assign ref_ok   = ({1'b0, wb} < 5'(BANKS)) && ({1'b0, wr} < 6'(ROWS));
  assign ref_addr = ADDR_W'(32'(wb) * ROWS + 32'(wr));
  assign mask     = 16'h8000 >> cx[3:0];
  assign pix_word = cmd.pix_on ? (rd_data | mask) : (rd_data & ~mask);
  assign ref_word = ref_ok ? rd_data : 16'h0000;

  always_ff @(posedge clk) begin
    if (cmd.pix_rd) begin
      rd_data <= mem[pix_addr];
    end else if (cmd.ref_rd && ref_ok) begin
      rd_data <= mem[ref_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_wr) begin
      mem[sweep_idx] <= cmd.fill_ones ? 16'hFFFF : 16'h0000;
    end else if (cmd.pix_wr) begin
      mem[pix_addr] <= pix_word;
    end
  end

  assign st.diag       = diag;
  assign st.at_end     = (cx == ex) && (cy == ey);
  assign st.on_screen  = ({1'b0, cx} < 9'(SCREEN_W)) && ({1'b0, cy} < 9'(SCREEN_H));
  assign st.sweep_last = (sweep_idx == ADDR_W'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      serial_byte  <= cmd.emit_ref ? frame_byte(cmd.byte_sel, wr, wb, ref_word) : 8'h00;
      byte_valid   <= cmd.emit_ref;
      out_of_range <= cmd.emit_ref ? ~ref_ok : skip;
      last         <= cmd.last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/monochrome_framebuffer_line_engine_top.sv =====
// top level of the monochrome frame buffer line engine: controller and
// datapath; uses mfle_pkg, mfle_ctrl, mfle_datapath
`default_nettype none

// An item is taken when start is high while busy is low. Results appear for
// one cycle each with strobe high and cannot be held off. After reset the
// frame store is cleared in a pass over all BANKS*ROWS words (512 by default)
// with busy high. Set or clear pixel reads its word then writes it back, or
// skips both when off screen; a line walks its pixels in turn, each
// on-screen pixel a read then a write on the single store port and each
// off-screen pixel skipped; a diagonal line reaches its end point and
// leaves it unplotted; fill and clear sweep the store one word a cycle;
// refresh reads one word then sends twelve bytes on consecutive cycles.
module monochrome_framebuffer_line_engine_top import mfle_pkg::*; #(
  parameter int BANKS = BANKS_DEF,
  parameter int ROWS  = ROWS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] opcode,
  input  wire logic [7:0] start_x,
  input  wire logic [7:0] start_y,
  input  wire logic [7:0] end_x,
  input  wire logic [7:0] end_y,
  input  wire logic [3:0] word_bank,
  input  wire logic [4:0] word_row,
  output logic            strobe,
  output logic [7:0]      serial_byte,
  output logic            byte_valid,
  output logic            out_of_range,
  output logic            last
);

  mfle_cmd_t    cmd;
  mfle_status_t st;

  mfle_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .st     (st),
    .busy   (busy),
    .cmd    (cmd)
  );

  mfle_datapath #(
    .BANKS (BANKS),
    .ROWS  (ROWS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .word_bank    (word_bank),
    .word_row     (word_row),
    .st           (st),
    .strobe       (strobe),
    .serial_byte  (serial_byte),
    .byte_valid   (byte_valid),
    .out_of_range (out_of_range),
    .last         (last)
  );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// self-checking testbench for monochrome_framebuffer_line_engine_top: directed
// pixel, line, fill and refresh items, then a random mix checked against a
// local frame store model; depends on rtl/mfle_pkg.sv and the top level rtl
`timescale 1ns / 1ps

module tb_top import mfle_pkg::*; ();

  localparam int BANKS    = BANKS_DEF;
  localparam int ROWS     = ROWS_DEF;
  localparam int SCREEN_W = (BANKS / 2) * 16;
  localparam int SCREEN_H = 2 * ROWS;
  localparam int LIMIT    = 1500000;
  localparam int RANDOM_ITEMS = 420;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    logic [7:0] sbyte;
    logic       valid;
    logic       oor;
    logic       lst;
  } link_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [2:0] opcode = '0;
  logic [7:0] start_x = '0;
  logic [7:0] start_y = '0;
  logic [7:0] end_x = '0;
  logic [7:0] end_y = '0;
  logic [3:0] word_bank = '0;
  logic [4:0] word_row = '0;
  logic       strobe;
  logic [7:0] serial_byte;
  logic       byte_valid;
  logic       out_of_range;
  logic       last;

  logic [15:0]  frame_words [0:BANKS*ROWS-1];
  link_result_t pending_results [$];
  link_result_t seen_result;
  link_result_t want_result;
  int           mismatches = 0;
  int           cycles = 0;
  bit           steady = 1'b0;
  int           recent_x = 0;
  int           recent_y = 0;

  monochrome_framebuffer_line_engine_top #(
    .BANKS(BANKS),
    .ROWS (ROWS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .word_bank   (word_bank),
    .word_row    (word_row),
    .strobe      (strobe),
    .serial_byte (serial_byte),
    .byte_valid  (byte_valid),
    .out_of_range(out_of_range),
    .last        (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------- frame store model ----------------

  function automatic bit plot_pixel(int x, int y, bit on);
    int          idx;
    logic [15:0] mask;
    if (x >= SCREEN_W || y >= SCREEN_H) return 1'b1;
    idx  = ((x / 16) + ((y >= ROWS) ? BANKS / 2 : 0)) * ROWS + (y % ROWS);
    mask = 16'h8000 >> (x % 16);
    if (on) frame_words[idx] = frame_words[idx] | mask;
    else frame_words[idx] = frame_words[idx] & ~mask;
    return 1'b0;
  endfunction

  function automatic bit trace_line(int ax, int ay, int bx, int by, bit on);
    int t;
    bit skipped;
    skipped = 1'b0;
    if (ax > bx) begin
      t = ax; ax = bx; bx = t;
    end
    if (ay > by) begin
      t = ay; ay = by; by = t;
    end
    if (ay == by) begin
      for (t = ax; t <= bx; t++) skipped |= plot_pixel(t, ay, on);
    end else if (ax == bx) begin
      for (t = ay; t <= by; t++) skipped |= plot_pixel(ax, t, on);
    end else begin
      // diagonal walk, end point itself is left out
      while (!(ax == bx && ay == by)) begin
        skipped |= plot_pixel(ax, ay, on);
        if (ax < bx) ax++;
        if (ay < by) ay++;
      end
    end
    return skipped;
  endfunction

  function automatic void push_framed(logic [7:0] sync, logic [7:0] value, logic oor,
                                      logic final_byte);
    pending_results.push_back('{sync, 1'b1, oor, 1'b0});
    pending_results.push_back('{value & NIBBLE_MASK, 1'b1, oor, 1'b0});
    pending_results.push_back('{{value[3:0], 4'h0}, 1'b1, oor, final_byte});
  endfunction

  function automatic void predict_item(logic [2:0] op, logic [7:0] sx, logic [7:0] sy,
                                       logic [7:0] ex, logic [7:0] ey,
                                       logic [3:0] bank, logic [4:0] row);
    bit          skipped;
    logic [15:0] word;
    logic        oor;
    skipped = 1'b0;
    case (op)
      OP_SET:   skipped = plot_pixel(sx, sy, 1'b1);
      OP_CLR:   skipped = plot_pixel(sx, sy, 1'b0);
      OP_DRAW:  skipped = trace_line(sx, sy, ex, ey, 1'b1);
      OP_ERASE: skipped = trace_line(sx, sy, ex, ey, 1'b0);
      OP_FILL:  foreach (frame_words[i]) frame_words[i] = 16'hFFFF;
      OP_CLEAR: foreach (frame_words[i]) frame_words[i] = 16'h0000;
      OP_REFRESH: begin
        word = 16'h0000;
        oor  = 1'b1;
        if (int'(bank) < BANKS && int'(row) < ROWS) begin
          word = frame_words[int'(bank) * ROWS + int'(row)];
          oor  = 1'b0;
        end
        push_framed(SYNC_CMD, CMD_MARK | {3'b000, row}, oor, 1'b0);
        push_framed(SYNC_CMD, CMD_MARK | {4'b0000, bank}, oor, 1'b0);
        push_framed(SYNC_DATA, word[15:8], oor, 1'b0);
        push_framed(SYNC_DATA, word[7:0], oor, 1'b1);
        return;
      end
      default: ;
    endcase
    pending_results.push_back('{8'h00, 1'b0, skipped, 1'b1});
  endfunction

  // ---------------- result checking ----------------

  always @(posedge clk) begin
    if (!rst && strobe) begin
      seen_result = '{serial_byte, byte_valid, out_of_range, last};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: byte %02h valid %0b oor %0b last %0b",
                   serial_byte, byte_valid, out_of_range, last);
      end else begin
        want_result = pending_results.pop_front();
        if (seen_result !== want_result) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %02h v%0b o%0b l%0b, got %02h v%0b o%0b l%0b",
                     want_result.sbyte, want_result.valid, want_result.oor, want_result.lst,
                     serial_byte, byte_valid, out_of_range, last);
        end
      end
    end
  end

  // ---------------- stimulus ----------------

  // called at a falling edge; start drops now and then while the
  // item waits, and is left high after it is taken
  task automatic send_item(logic [2:0] op, logic [7:0] sx, logic [7:0] sy,
                           logic [7:0] ex, logic [7:0] ey,
                           logic [3:0] bank, logic [4:0] row);
    bit taken;
    opcode    = op;
    start_x   = sx;
    start_y   = sy;
    end_x     = ex;
    end_y     = ey;
    word_bank = bank;
    word_row  = row;
    taken     = 1'b0;
    while (!taken) begin
      start = steady || ($urandom_range(0, 99) >= 19);
      @(posedge clk);
      taken = start && !busy;
      @(negedge clk);
    end
    predict_item(op, sx, sy, ex, ey, bank, row);
  endtask

  task automatic check_pixel_ops;
    send_item(OP_SET, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0, 5'd0);
    send_item(OP_SET, 8'd127, 8'd63, 8'd255, 8'd255, 4'd15, 5'd31);
    send_item(OP_SET, 8'd255, 8'd255, 8'd0, 8'd0, 4'd0, 5'd0);
    send_item(OP_SET, 8'd128, 8'd5, 8'd0, 8'd0, 4'd0, 5'd0);
    send_item(OP_SET, 8'd3, 8'd64, 8'd0, 8'd0, 4'd0, 5'd0);
    send_item(OP_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0, 5'd0);
    send_item(OP_CLR, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0, 5'd0);
    send_item(OP_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 4'd15, 5'd31);
  endtask

  task automatic check_line_ops;
    // horizontal, reversed vertical, mixed diagonal, diagonal leaving screen, single point
    send_item(OP_DRAW, 8'd0, 8'd10, 8'd127, 8'd10, 4'd0, 5'd0);
    send_item(OP_DRAW, 8'd40, 8'd63, 8'd40, 8'd0, 4'd0, 5'd0);
    send_item(OP_DRAW, 8'd100, 8'd50, 8'd90, 8'd20, 4'd0, 5'd0);
    send_item(OP_DRAW, 8'd120, 8'd60, 8'd200, 8'd70, 4'd0, 5'd0);
    send_item(OP_DRAW, 8'd5, 8'd5, 8'd5, 8'd5, 4'd0, 5'd0);
    send_item(OP_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 4'd2, 5'd10);
    send_item(OP_ERASE, 8'd127, 8'd10, 8'd0, 8'd10, 4'd0, 5'd0);
    send_item(OP_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 4'd2, 5'd10);
  endtask

  task automatic check_fill_and_clear;
    send_item(OP_FILL, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0, 5'd0);
    send_item(OP_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 4'd7, 5'd5);
    send_item(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'hF, 5'h1F);
    send_item(OP_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0, 5'd0);
    send_item(OP_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 4'd7, 5'd5);
  endtask

  // mostly on screen, now and then anywhere in the field range
  function automatic logic [7:0] pick_coord(int lim);
    if ($urandom_range(0, 99) < 12) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, lim - 1));
  endfunction

  function automatic logic [7:0] pick_near(logic [7:0] c, int lim);
    int v;
    if ($urandom_range(0, 99) < 30) return pick_coord(lim);
    v = int'(c) + int'($urandom_range(0, 48)) - 24;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  task automatic run_random_mix;
    int         r;
    logic [2:0] op;
    logic [7:0] sx, sy, ex, ey;
    logic [3:0] bank;
    logic [4:0] row;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 150 && n < 250);
      r  = $urandom_range(0, 99);
      sx = pick_coord(SCREEN_W);
      sy = pick_coord(SCREEN_H);
      ex = pick_near(sx, SCREEN_W);
      ey = pick_near(sy, SCREEN_H);
      bank = 4'($urandom_range(0, 15));
      row  = 5'($urandom_range(0, 31));
      if (r < 15) op = OP_SET;
      else if (r < 27) op = OP_CLR;
      else if (r < 47) op = OP_DRAW;
      else if (r < 57) op = OP_ERASE;
      else if (r < 59) op = OP_FILL;
      else if (r < 61) op = OP_CLEAR;
      else if (r < 63) op = OP_UNUSED;
      else op = OP_REFRESH;
      // refresh usually the word holding the last touched pixel
      if (op == OP_REFRESH && $urandom_range(0, 99) < 60 &&
          recent_x < SCREEN_W && recent_y < SCREEN_H) begin
        bank = 4'(recent_x / 16 + ((recent_y >= ROWS) ? BANKS / 2 : 0));
        row  = 5'(recent_y % ROWS);
      end
      if (op <= OP_ERASE) begin
        recent_x = (op >= OP_DRAW && $urandom_range(0, 1)) ? int'(ex) : int'(sx);
        recent_y = (op >= OP_DRAW && $urandom_range(0, 1)) ? int'(ey) : int'(sy);
      end
      send_item(op, sx, sy, ex, ey, bank, row);
    end
    steady = 1'b0;
  endtask

  initial begin
    foreach (frame_words[i]) frame_words[i] = 16'h0000;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    check_pixel_ops();
    check_line_ops();
    check_fill_and_clear();
    run_random_mix();
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
